/* rtl/dcrg_pkg.sv */
// Shared constants, types and state codes for the DC removal gain buffer.
package dcrg_pkg;

  localparam int MAX_SAMPLES = 65536;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = CNT_W + SAMPLE_W;
  localparam int GAIN_W      = 10;
  localparam int DVD_W       = SUM_W - 1;
  localparam int DVS_W       = CNT_W;
  localparam int DIV_STEP_W  = $clog2(DVD_W);
  localparam int PROD_W      = SAMPLE_W + 1 + GAIN_W + 1;

  // x / 100 as (x * ceil(2^34 / 100)) >> 34, exact for x below 2^27
  localparam int RECIP_M_W   = 28;
  localparam int RECIP_SH    = 34;
  localparam int RECIP_W     = PROD_W + RECIP_M_W;

  localparam logic [GAIN_W-1:0]    GAIN_RESET   = GAIN_W'(100);
  localparam logic [RECIP_M_W-1:0] RECIP_100    = 28'd171798692;
  localparam logic [SAMPLE_W-1:0]  SAT_POS      = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0]  SAT_NEG      = 16'h8000;
  localparam logic [DVD_W-1:0]     SAT_POS_MAG  = DVD_W'(32767);
  localparam logic [DVD_W-1:0]     SAT_NEG_MAG  = DVD_W'(32768);

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_FETCH = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_FETCH,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_OFS,
    ST_READ,
    ST_MUL,
    ST_DSTART,
    ST_DIV_GAIN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/dcrg_ram.sv */
// Generic single-port RAM with registered read.
module dcrg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/dcrg_div.sv */
// Restoring serial divider for unsigned magnitudes, one quotient bit per cycle.
module dcrg_div
  import dcrg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]      dvd_r, dvd_nxt;
  logic [DVS_W-1:0]      dvs_r, dvs_nxt;
  logic [DVS_W-1:0]      rem_r, rem_nxt;
  logic [DVS_W:0]        rem_sh;
  logic                  ge;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      dvd_nxt  = {dvd_r[DVD_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_STEP_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

/* rtl/dcrg_front.sv */
// Input stage: accepts words, decodes the action and queues them for the back end.
module dcrg_front
  import dcrg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [SAMPLE_W-1:0] in_sample_in,
  output logic                q_valid,
  output q_entry_t            q_head,
  input  logic                q_pop
);

  q_entry_t    ent_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        known;
  logic        push;
  op_t         op;

  always_comb begin
    known = 1'b1;
    op    = OP_PUSH;
    unique case (in_action)
      ACT_PUSH:  op = OP_PUSH;
      ACT_FETCH: op = OP_FETCH;
      ACT_CLEAR: op = OP_CLEAR;
      default:   known = 1'b0;
    endcase
  end

  assign in_ready = cnt_r != 2'd2;
  assign push     = in_valid && in_ready && known;
  assign q_valid  = cnt_r != 2'd0;
  assign q_head   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= '{op: op, sample: in_sample_in};
    end
  end

endmodule

/* rtl/dcrg_back.sv */
// Execution stage: capture store, offset, gain, saturation and the output register.
module dcrg_back
  import dcrg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  q_entry_t            q_head,
  output logic                q_pop,
  input  logic                cfg_we,
  input  logic [GAIN_W-1:0]   cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_sample_out,
  output logic [SAMPLE_W-1:0] out_dc_offset,
  output logic [SAMPLE_W-1:0] out_peak_level,
  output logic                out_last
);

  back_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] ofs_r, ofs_nxt;
  logic                ofs_rdy_r, ofs_rdy_nxt;
  logic [SAMPLE_W-1:0] peak_r, peak_nxt;
  logic [GAIN_W-1:0]   gain_r;
  logic                neg_r, neg_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [RECIP_W-1:0]  recip_r, recip_nxt;
  logic [SAMPLE_W-1:0] res_val_r, res_val_nxt;
  logic [SAMPLE_W-1:0] res_mag_r, res_mag_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;
  logic [SAMPLE_W-1:0] out_sample_r, out_ofs_r, out_peak_r;
  logic                out_last_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;
  div_req_t            dreq;
  div_rsp_t            drsp;

  logic [SUM_W-1:0]    sum_abs;
  logic [PROD_W-1:0]   prod_abs;
  logic [SAMPLE_W:0]   diff;
  logic [DVD_W-1:0]    q;
  logic [DVD_W-1:0]    gq;
  logic [SAMPLE_W-1:0] peak_cand;

  dcrg_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(q_head.sample),
    .rdata(ram_rdata)
  );

  dcrg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign sum_abs  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : sum_r;
  assign prod_abs = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : prod_r;
  assign diff     = {ram_rdata[SAMPLE_W-1], ram_rdata} - {ofs_r[SAMPLE_W-1], ofs_r};
  assign q        = drsp.quotient;
  assign gq       = DVD_W'(recip_r[RECIP_W-1:RECIP_SH]);
  assign out_load = !out_valid_r || out_ready;
  assign ram_addr = (state_r == ST_READ) ? rd_idx_r[ADDR_W-1:0] : count_r[ADDR_W-1:0];
  assign peak_cand = (res_mag_r > peak_r) ? res_mag_r : peak_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    sum_nxt       = sum_r;
    ofs_nxt       = ofs_r;
    ofs_rdy_nxt   = ofs_rdy_r;
    peak_nxt      = peak_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    recip_nxt     = recip_r;
    res_val_nxt   = res_val_r;
    res_mag_nxt   = res_mag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = sum_abs[DVD_W-1:0];
    dreq.divisor  = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            OP_PUSH: begin
              if (!ofs_rdy_r && count_r != CNT_W'(MAX_SAMPLES)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                sum_nxt   = sum_r + SUM_W'($signed(q_head.sample));
              end
            end
            OP_FETCH: begin
              if (count_r != '0) begin
                if (!ofs_rdy_r) begin
                  dreq.start = 1'b1;
                  neg_nxt    = sum_r[SUM_W-1];
                  state_nxt  = ST_DIV_OFS;
                end else if (rd_idx_r < count_r) begin
                  state_nxt = ST_READ;
                end
              end
            end
            OP_CLEAR: begin
              count_nxt   = '0;
              rd_idx_nxt  = '0;
              sum_nxt     = '0;
              ofs_nxt     = '0;
              ofs_rdy_nxt = 1'b0;
              peak_nxt    = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV_OFS: begin
        if (drsp.done) begin
          ofs_nxt     = neg_r ? SAMPLE_W'(-q[SAMPLE_W-1:0]) : q[SAMPLE_W-1:0];
          ofs_rdy_nxt = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = $signed({{(PROD_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff}) *
                    $signed({{(PROD_W-GAIN_W){1'b0}}, gain_r});
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        recip_nxt = RECIP_W'(prod_abs) * RECIP_W'(RECIP_100);
        neg_nxt   = prod_r[PROD_W-1];
        state_nxt = ST_DIV_GAIN;
      end
      ST_DIV_GAIN: begin
        if (neg_r) begin
          if (gq > SAT_NEG_MAG) begin
            res_val_nxt = SAT_NEG;
            res_mag_nxt = SAT_NEG;
          end else begin
            res_val_nxt = SAMPLE_W'(-gq[SAMPLE_W-1:0]);
            res_mag_nxt = gq[SAMPLE_W-1:0];
          end
        end else begin
          if (gq > SAT_POS_MAG) begin
            res_val_nxt = SAT_POS;
            res_mag_nxt = SAT_POS;
          end else begin
            res_val_nxt = gq[SAMPLE_W-1:0];
            res_mag_nxt = gq[SAMPLE_W-1:0];
          end
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          peak_nxt      = peak_cand;
          rd_idx_nxt    = rd_idx_r + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      sum_r       <= '0;
      ofs_r       <= '0;
      ofs_rdy_r   <= 1'b0;
      peak_r      <= '0;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      sum_r       <= sum_nxt;
      ofs_r       <= ofs_nxt;
      ofs_rdy_r   <= ofs_rdy_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_r     <= neg_nxt;
    prod_r    <= prod_nxt;
    recip_r   <= recip_nxt;
    res_val_r <= res_val_nxt;
    res_mag_r <= res_mag_nxt;
    if (state_r == ST_EMIT && out_load) begin
      out_sample_r <= res_val_r;
      out_ofs_r    <= ofs_r;
      out_peak_r   <= peak_cand;
      out_last_r   <= (rd_idx_r + 1'b1) == count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_dc_offset  = out_ofs_r;
  assign out_peak_level = out_peak_r;
  assign out_last       = out_last_r;

endmodule

/* rtl/dc_removal_gain_buffer_unit.sv */
// DC removal gain buffer: top level joining the input queue and the execution stage.
//
// Input words carry an action and a signed 16-bit sample. Push stores the sample
// (up to 65536 of them) and adds it to a running sum; fetch returns the next stored
// sample with the DC offset removed and the gain applied; clear restarts capture.
// Pushes after the first fetch, pushes into a full store, fetches on an empty store
// or past the end, and action code 3 produce no output word.
// cfg_we/cfg_wdata set the gain in percent (100 after reset); the user must write it
// only while the block is idle, which the block itself does not enforce. A two-entry
// queue sits between the input and the execution stage, so input words keep being
// taken while a result waits at the output register. A push is handled in the idle
// state as it is popped. A fetch passes through the execution stage in order: read,
// multiply, reciprocal multiply for the division by 100, saturate, emit; the first
// fetch after a capture first divides the sum by the sample count on the 32-step
// serial divider.
// Reset (rst_n low, synchronous) empties the queue and the output register and
// clears the capture state; the sample store keeps its contents.
// When out_ready is low the result holds in the output register, the execution stage
// waits on the next result, and the queue fills before in_ready drops.
module dc_removal_gain_buffer_unit
  import dcrg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [SAMPLE_W-1:0] in_sample_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_sample_out,
  output logic [SAMPLE_W-1:0] out_dc_offset,
  output logic [SAMPLE_W-1:0] out_peak_level,
  output logic                out_last,
  input  logic                cfg_we,
  input  logic [GAIN_W-1:0]   cfg_wdata
);

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  dcrg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_sample_in(in_sample_in),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  dcrg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_dc_offset (out_dc_offset),
    .out_peak_level(out_peak_level),
    .out_last      (out_last)
  );

endmodule

/* rtl/dcrg_checker.sv */
// Port-level checks for the DC removal gain buffer, bound to the top level.
module dcrg_checker
  import dcrg_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_sample_out,
  input logic [SAMPLE_W-1:0] out_peak_level
);

  logic [SAMPLE_W:0] mag;

  assign mag = out_sample_out[SAMPLE_W-1] ?
               (SAMPLE_W+1)'(-$signed(out_sample_out)) : {1'b0, out_sample_out};

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("stalled output word changed");

  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_peak_level} >= mag)
    else $error("peak below current sample magnitude");

  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_level <= SAT_NEG)
    else $error("peak out of range");

endmodule

bind dc_removal_gain_buffer_unit dcrg_checker u_dcrg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_sample_out(out_sample_out),
  .out_peak_level(out_peak_level)
);
